// ===== hdl/ffea_pkg.sv =====
// shared constants, status codes and controller/datapath interface types
package ffea_pkg;
   localparam int SLOTS     = 16;
   localparam int MEM_WORDS = 64 * 1024;
   localparam int ADDR_W    = 16;
   localparam int WIDE_W    = 18;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef logic [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic       load;
      logic       rd;
      logic       take;
      logic       push_new;
      logic       push_old;
      logic       next;
      logic       flush;
      logic       resp;
      logic [1:0] resp_status;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic full;
      logic fit;
      logic insert_now;
      logic last;
      logic inserted;
   } stat_type;
endpackage

// ===== hdl/ffea_ctrl.sv =====
// sequencer for the allocate walk and the free insert and merge pass
module ffea_ctrl import ffea_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_PROC  = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_free && stat.full) begin
               cmd.resp        = 1'b1;
               cmd.resp_status = ST_FULL;
               state_in        = S_IDLE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_PROC;
         end
         S_PROC: begin
            if (!stat.is_free) begin
               if (stat.fit) begin
                  cmd.take        = 1'b1;
                  cmd.resp        = 1'b1;
                  cmd.resp_status = ST_OK;
                  state_in        = S_IDLE;
               end else if (stat.last) begin
                  cmd.resp        = 1'b1;
                  cmd.resp_status = ST_NOMEM;
                  state_in        = S_IDLE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = S_RD;
               end
            end else if (stat.insert_now) begin
               cmd.push_new = 1'b1;
            end else begin
               cmd.push_old = 1'b1;
               cmd.next     = 1'b1;
               state_in     = stat.last ? S_TAIL : S_RD;
            end
         end
         S_TAIL: begin
            cmd.push_new = !stat.inserted;
            state_in     = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.flush       = 1'b1;
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_OK;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hdl/ffea_dpath.sv =====
// extent table, merge accumulator and result registers
module ffea_dpath import ffea_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              req_type,
   input  logic [ADDR_W-1:0] req_block_size,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_granted_address
);
   wide_type mem_start [SLOTS];
   wide_type mem_len   [SLOTS];

   logic              entry0_valid_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              type_ff;
   logic [ADDR_W-1:0] size_ff, addr_ff;
   logic [IDX_W-1:0]  rd_idx_ff, keep_ff;
   logic              ins_ff, have_cur_ff;
   wide_type          dat_start_ff, dat_len_ff;
   wide_type          cur_start_ff, cur_len_ff;
   logic              strobe_ff;
   logic [1:0]        status_ff;
   logic [ADDR_W-1:0] grant_ff;

   wide_type           size_w, addr_w, item_start, item_len, merged_len;
   logic [WIDE_W:0]    cur_end, item_end;
   logic               do_push, touch, wr_en;
   logic [IDX_W-1:0]   wr_idx;
   wide_type           wr_start, wr_len;

   assign size_w = {{(WIDE_W-ADDR_W){1'b0}}, size_ff};
   assign addr_w = {{(WIDE_W-ADDR_W){1'b0}}, addr_ff};

   assign stat.is_free    = (type_ff == REQ_FREE);
   assign stat.full       = (count_ff >= CNT_W'(SLOTS));
   assign stat.fit        = (dat_len_ff >= size_w);
   assign stat.insert_now = !ins_ff && (dat_start_ff > addr_w);
   assign stat.last       = ({1'b0, rd_idx_ff} == CNT_W'(count_ff - 1'b1));
   assign stat.inserted   = ins_ff;

   assign do_push    = cmd.push_new || cmd.push_old;
   assign item_start = cmd.push_new ? addr_w : dat_start_ff;
   assign item_len   = cmd.push_new ? size_w : dat_len_ff;
   assign cur_end    = {1'b0, cur_start_ff} + {1'b0, cur_len_ff};
   assign item_end   = {1'b0, item_start} + {1'b0, item_len};
   assign touch      = (cur_end >= {1'b0, item_start});
   assign merged_len = WIDE_W'(item_end - {1'b0, cur_start_ff});

   // one write port: allocate trim, merge spill or final flush
   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = keep_ff;
      wr_start = cur_start_ff;
      wr_len   = cur_len_ff;
      priority if (cmd.take) begin
         wr_en    = 1'b1;
         wr_idx   = rd_idx_ff;
         wr_start = dat_start_ff + size_w;
         wr_len   = dat_len_ff - size_w;
      end else if (do_push && have_cur_ff && !touch) begin
         wr_en = 1'b1;
      end else if (cmd.flush) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_idx] <= wr_start;
         mem_len[wr_idx]   <= wr_len;
      end
      if (cmd.rd) begin
         if (rd_idx_ff == '0 && !entry0_valid_ff) begin
            dat_start_ff <= '0;
            dat_len_ff   <= WIDE_W'(MEM_WORDS);
         end else begin
            dat_start_ff <= mem_start[rd_idx_ff];
            dat_len_ff   <= mem_len[rd_idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         size_ff <= req_block_size;
         addr_ff <= req_block_address;
      end
      if (do_push) begin
         if (!have_cur_ff || !touch) begin
            cur_start_ff <= item_start;
            cur_len_ff   <= item_len;
         end else begin
            cur_len_ff <= merged_len;
         end
      end
      if (cmd.resp) begin
         status_ff <= cmd.resp_status;
         grant_ff  <= cmd.take ? dat_start_ff[ADDR_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry0_valid_ff <= 1'b0;
         count_ff        <= CNT_W'(1);
         rd_idx_ff       <= '0;
         keep_ff         <= '0;
         ins_ff          <= 1'b0;
         have_cur_ff     <= 1'b0;
         strobe_ff       <= 1'b0;
      end else begin
         strobe_ff <= cmd.resp;
         if (wr_en && wr_idx == '0) begin
            entry0_valid_ff <= 1'b1;
         end
         if (cmd.load) begin
            rd_idx_ff   <= '0;
            keep_ff     <= '0;
            ins_ff      <= 1'b0;
            have_cur_ff <= 1'b0;
         end else begin
            if (cmd.next) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if (cmd.push_new) begin
               ins_ff <= 1'b1;
            end
            if (do_push) begin
               have_cur_ff <= 1'b1;
               if (have_cur_ff && !touch) begin
                  keep_ff <= keep_ff + 1'b1;
               end
            end
            if (cmd.flush) begin
               count_ff <= CNT_W'(keep_ff) + 1'b1;
            end
         end
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_address = grant_ff;
endmodule

// ===== hdl/first_fit_extent_allocator.sv =====
// first-fit extent allocator: walks the table extent by extent, a read then a process state
// allocate: visits k extents (at most SLOTS) in table order and trims the first that fits
// free: walks every extent, inserting the new one in address order and merging neighbours,
// then flushes; a full table gets ST_FULL from the check state; busy drops in the strobe cycle
// one transaction at a time, the entry-by-entry table walk sets the rate; receiver cannot stall
// synchronous reset leaves one extent covering all of memory and the block idle
module first_fit_extent_allocator import ffea_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [ADDR_W-1:0] req_block_size,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_granted_address
);
   cmd_type  cmd;
   stat_type stat;

   ffea_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffea_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_block_size      (req_block_size),
      .req_block_address   (req_block_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );
endmodule

// ===== sim/tb_first_fit_extent_allocator.sv =====
// self-checking testbench for the first-fit extent allocator
module tb_first_fit_extent_allocator import ffea_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1300;

   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
   } grant_type;

   typedef struct {
      logic              kind;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              typed;
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = REQ_ALLOC;
   logic [ADDR_W-1:0] req_block_size = '0;
   logic [ADDR_W-1:0] req_block_address = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_granted_address;

   // shadow copy of the free list
   wide_type  free_start [SLOTS];
   wide_type  free_len [SLOTS];
   int        free_count;
   grant_type pending_grants [$];
   int        errors = 0;
   int        quiet_cycles = 0;
   bit        stim_done = 0;

   first_fit_extent_allocator uut (.*);

   always #6 clock = ~clock;

   function automatic grant_type predict_request(logic kind, logic [ADDR_W-1:0] size,
                                                  logic [ADDR_W-1:0] addr);
      grant_type g;
      int pos, keep;
      logic [WIDE_W:0] keep_end, later_end;
      g.status = ST_NOMEM;
      g.address = '0;
      if (kind == REQ_ALLOC) begin
         for (int i = 0; i < free_count; i++) begin
            if (free_len[i] >= WIDE_W'(size)) begin
               g.status = ST_OK;
               g.address = free_start[i][ADDR_W-1:0];
               free_start[i] = free_start[i] + WIDE_W'(size);
               free_len[i] = free_len[i] - WIDE_W'(size);
               break;
            end
         end
      end else if (free_count >= SLOTS) begin
         g.status = ST_FULL;
      end else begin
         pos = 0;
         while (pos < free_count && free_start[pos] <= WIDE_W'(addr)) pos++;
         for (int j = free_count; j > pos; j--) begin
            free_start[j] = free_start[j-1];
            free_len[j] = free_len[j-1];
         end
         free_start[pos] = WIDE_W'(addr);
         free_len[pos] = WIDE_W'(size);
         free_count++;
         keep = 0;
         for (int j = 1; j < free_count; j++) begin
            keep_end = {1'b0, free_start[keep]} + {1'b0, free_len[keep]};
            if (keep_end >= {1'b0, free_start[j]}) begin
               later_end = {1'b0, free_start[j]} + {1'b0, free_len[j]};
               free_len[keep] = WIDE_W'(later_end - {1'b0, free_start[keep]});
            end else begin
               keep++;
               free_start[keep] = free_start[j];
               free_len[keep] = free_len[j];
            end
         end
         free_count = keep + 1;
         g.status = ST_OK;
      end
      return g;
   endfunction

   task automatic issue(logic kind, logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr,
                        bit typed = 0, logic [1:0] st = ST_OK,
                        logic [ADDR_W-1:0] ad = '0);
      grant_type g;
      while ($urandom_range(99) < 9 && !stim_done) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_block_size <= size;
      req_block_address <= addr;
      do @(posedge clock); while (busy);
      g = predict_request(kind, size, addr);
      if (typed && (g.status !== st || g.address !== ad)) begin
         $display("%0t table row disagrees with predictor: expected %0d/%h actual %0d/%h",
                  $time, st, ad, g.status, g.address);
         errors++;
      end
      pending_grants.push_back(g);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_grants.size() == 0) begin
            $display("%0t unexpected transaction: actual %0d/%h", $time, rsp_status,
                     rsp_granted_address);
            errors++;
         end else begin
            if (rsp_status !== pending_grants[0].status) begin
               $display("%0t status: expected %0d actual %0d", $time,
                        pending_grants[0].status, rsp_status);
               errors++;
            end
            if (rsp_granted_address !== pending_grants[0].address) begin
               $display("%0t granted_address: expected %h actual %h", $time,
                        pending_grants[0].address, rsp_granted_address);
               errors++;
            end
            void'(pending_grants.pop_front());
         end
      end
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   stim_row_type directed [] = '{
      '{REQ_ALLOC, 16'd0,     16'd0,     1, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'hFFFF,  16'd0,     1, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'd1,     16'd0,     1, ST_OK,    16'hFFFF},
      '{REQ_ALLOC, 16'd1,     16'd0,     1, ST_NOMEM, 16'h0000},
      '{REQ_ALLOC, 16'd0,     16'd0,     1, ST_OK,    16'h0000},
      '{REQ_FREE,  16'd16,    16'h0100,  1, ST_OK,    16'h0000},
      '{REQ_FREE,  16'd8,     16'h0100,  0, ST_OK,    16'h0000},
      '{REQ_FREE,  16'd4,     16'h0104,  0, ST_OK,    16'h0000},
      '{REQ_FREE,  16'd0,     16'h0200,  0, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'd16,    16'hAAAA,  0, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'd0,     16'd0,     0, ST_OK,    16'h0000},
      '{REQ_FREE,  16'hFFFF,  16'hFFFF,  0, ST_OK,    16'h0000},
      '{REQ_FREE,  16'd10,    16'h0110,  0, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'd10,    16'd0,     0, ST_OK,    16'h0000},
      '{REQ_ALLOC, 16'hFFFF,  16'd0,     0, ST_OK,    16'h0000}
   };

   initial begin
      int n;
      for (int i = 0; i < SLOTS; i++) begin
         free_start[i] = '0;
         free_len[i] = '0;
      end
      free_len[0] = WIDE_W'(MEM_WORDS);
      free_count = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         issue(directed[i].kind, directed[i].size, directed[i].addr, directed[i].typed,
               directed[i].status, directed[i].address);
      // fragment the table with single-word frees to reach table-full
      for (int i = 0; i < 20; i++)
         issue(REQ_FREE, 16'd1, 16'(16'h4000 + 4 * i));
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // idle-free stretch in the middle of the run
         if (n == 400) stim_done = 1;
         if (n == 700) stim_done = 0;
         if ($urandom_range(1)) begin
            case ($urandom_range(3))
               0: issue(REQ_ALLOC, 16'($urandom_range(64)), 16'($urandom));
               1: issue(REQ_ALLOC, 16'($urandom), 16'($urandom));
               default: issue(REQ_ALLOC, 16'($urandom_range(4096)), 16'($urandom));
            endcase
         end else begin
            case ($urandom_range(3))
               0: issue(REQ_FREE, 16'($urandom_range(64)), 16'($urandom));
               1: issue(REQ_FREE, 16'($urandom), 16'($urandom));
               default: issue(REQ_FREE, 16'($urandom_range(8)), 16'($urandom_range(16'hFFFF)
                              & 16'hFFF0));
            endcase
         end
      end
      start <= 1'b0;
      stim_done = 1;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== first_fit_extent_allocator.f =====
hdl/ffea_pkg.sv
hdl/ffea_ctrl.sv
hdl/ffea_dpath.sv
hdl/first_fit_extent_allocator.sv
sim/tb_first_fit_extent_allocator.sv
